// ----- src/pphit_pkg.sv -----
// Shared types and constants of the polyline and polygon hit test.
`timescale 1ns / 1ps
`default_nettype none
package pphit_pkg;

  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned COUNT_BITS  = 16;
  localparam int unsigned SCALE_SHIFT = 16;

  // Outcode bits against the width box around the query point
  localparam logic [3:0] OC_LEFT  = 4'h1;
  localparam logic [3:0] OC_RIGHT = 4'h2;
  localparam logic [3:0] OC_BELOW = 4'h4;
  localparam logic [3:0] OC_ABOVE = 4'h8;

  // Element kinds
  localparam logic KIND_STRIP = 1'b0;
  localparam logic KIND_POLY  = 1'b1;

  // Width scaling modes
  localparam logic [1:0] MODE_NONE       = 2'd0;
  localparam logic [1:0] MODE_NORMAL     = 2'd1;
  localparam logic [1:0] MODE_VERTICAL   = 2'd2;
  localparam logic [1:0] MODE_HORIZONTAL = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_QUERY_X    = 3'd0;
  localparam logic [2:0] REG_QUERY_Y    = 3'd1;
  localparam logic [2:0] REG_SCALE_NORM = 3'd2;
  localparam logic [2:0] REG_SCALE_VERT = 3'd3;
  localparam logic [2:0] REG_SCALE_HORZ = 3'd4;

  localparam logic [31:0] SCALE_RESET = 32'h0001_0000;
  localparam logic [31:0] WIDTH_MAX   = 32'h7FFF_FFFF;

  typedef struct packed {
    logic signed [31:0] vert_x;
    logic signed [31:0] vert_y;
    logic               prim_kind;
    logic [1:0]         scale_mode;
    logic [23:0]        stroke_width;
    logic               first_vertex;
    logic               last_vertex;
  } pphit_in_t;

  typedef struct packed {
    logic hit;
    logic skipped;
  } pphit_out_t;

endpackage
`default_nettype wire

// ----- src/polyline_polygon_hit_test.sv -----
// Top level: hit test of streamed strip and polygon vertices on one shared multiplier.
// Sequencing: the input stalls from acceptance until the sequencer is back in idle; an opening
//   strip vertex sets up its width first, a strip vertex may run the full segment test, a polygon vertex an edge test.
// Throughput: one item at a time, set by the 34x34 multiply-accumulate unit, which every multiply
//   step of a strip vertex passes through; a stalled result holds the last vertex in its finish state.
// Reset (rst_ni low, asynchronous) clears all control state; query point zero, factors 1.0.
`timescale 1ns / 1ps
`default_nettype none
module polyline_polygon_hit_test
  import pphit_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire pphit_in_t   in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output pphit_out_t       out_data_o
);

  // Sequencer states
  localparam logic [5:0] S_IDLE = 6'd0,  S_SCALE = 6'd1,  S_WSET = 6'd2,  S_W2 = 6'd3;
  localparam logic [5:0] S_W2ST = 6'd4,  S_OC = 6'd5,     S_V0 = 6'd6,    S_V1 = 6'd7;
  localparam logic [5:0] S_V2 = 6'd8,    S_VCHK = 6'd9,   S_L0 = 6'd10,   S_L1 = 6'd11;
  localparam logic [5:0] S_LST = 6'd12,  S_D0 = 6'd13,    S_D1 = 6'd14,   S_DCHK = 6'd15;
  localparam logic [5:0] S_C0 = 6'd16,   S_C1 = 6'd17,    S_CST = 6'd18,  S_Q0 = 6'd19;
  localparam logic [5:0] S_Q1 = 6'd20,   S_Q2 = 6'd21,    S_Q3 = 6'd22,   S_Q4 = 6'd23;
  localparam logic [5:0] S_Q5 = 6'd24,   S_Q6 = 6'd25,    S_QCHK = 6'd26, S_ESEL = 6'd27;
  localparam logic [5:0] S_E0 = 6'd28,   S_E1 = 6'd29,    S_ECHK = 6'd30, S_EEND = 6'd31;
  localparam logic [5:0] S_FIN = 6'd32;

  // Product shift codes
  localparam logic [1:0] SH_0 = 2'd0, SH_32 = 2'd1, SH_33 = 2'd2, SH_64 = 2'd3;

  localparam int unsigned ACC_W = 130;

  logic [5:0]              state_q, state_d;
  pphit_in_t               item_q;
  logic signed [31:0]      qx_q, qy_q;
  logic [31:0]             sc_norm_q, sc_vert_q, sc_horz_q;
  logic signed [31:0]      prev_x_q, prev_y_q, start_x_q, start_y_q;
  logic [3:0]              prev_oc_q, oc_q;
  logic [31:0]             w_q;
  logic [63:0]             w2_q;
  logic [65:0]             len2_q;
  logic [63:0]             crs_q;
  logic [COUNT_BITS-1:0]   count_q;
  logic                    parity_q, hit_q, kind_q, zw_q, open_q, seg_ok_q, closing_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    out_valid_q;
  pphit_out_t              out_q;

  logic                    in_acc, open_new, out_free;
  logic signed [33:0]      xe, ye, qxe, qye, we;
  logic signed [33:0]      dx, dy, vx, vy, wx, wy;
  logic signed [33:0]      x0e, y0e, x1e, y1e, ex, ey, gx, gy;
  logic                    crossing;
  logic [3:0]              oc;
  logic [31:0]             factor;
  logic [31:0]             w_new;
  logic signed [33:0]      mul_a, mul_b;
  logic [1:0]              mul_sh;
  logic                    mul_en, mul_clr, mul_neg;
  logic signed [67:0]      prod;
  logic signed [ACC_W-1:0] prod_ext, term, acc_d;
  logic signed [ACC_W-1:0] ldiff, acc_mag;
  logic                    acc_zero, acc_neg, acc_pos, result_skip;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign open_new = in_data_i.first_vertex || (count_q == '0);
  assign out_free = !out_valid_q || !out_stall_i;

  // Extended coordinates and differences
  assign xe  = {{2{item_q.vert_x[31]}}, item_q.vert_x};
  assign ye  = {{2{item_q.vert_y[31]}}, item_q.vert_y};
  assign qxe = {{2{qx_q[31]}}, qx_q};
  assign qye = {{2{qy_q[31]}}, qy_q};
  assign we  = {2'b00, w_q};
  assign dx  = xe - qxe;
  assign dy  = ye - qye;
  assign vx  = xe - {{2{prev_x_q[31]}}, prev_x_q};
  assign vy  = ye - {{2{prev_y_q[31]}}, prev_y_q};
  assign wx  = qxe - {{2{prev_x_q[31]}}, prev_x_q};
  assign wy  = qye - {{2{prev_y_q[31]}}, prev_y_q};

  // Polygon edge endpoints: closing edge runs from this vertex back to the start
  always_comb begin
    if (closing_q) begin
      x0e = xe;
      y0e = ye;
      x1e = {{2{start_x_q[31]}}, start_x_q};
      y1e = {{2{start_y_q[31]}}, start_y_q};
    end else begin
      x0e = {{2{prev_x_q[31]}}, prev_x_q};
      y0e = {{2{prev_y_q[31]}}, prev_y_q};
      x1e = xe;
      y1e = ye;
    end
  end
  assign ex = x1e - x0e;
  assign ey = y1e - y0e;
  assign gx = qxe - x0e;
  assign gy = qye - y0e;
  assign crossing = (y1e < qye) != (y0e < qye);

  // Outcode against the width box
  always_comb begin
    oc = 4'h0;
    if (xe < qxe - we) oc = oc | OC_LEFT;
    if (xe > qxe + we) oc = oc | OC_RIGHT;
    if (ye < qye - we) oc = oc | OC_BELOW;
    if (ye > qye + we) oc = oc | OC_ABOVE;
  end

  // Width factor of the element's mode
  always_comb begin
    case (item_q.scale_mode)
      MODE_NORMAL:   factor = sc_norm_q;
      MODE_VERTICAL: factor = sc_vert_q;
      default:       factor = sc_horz_q;
    endcase
  end

  // Scaled width, saturated; the stroke width as given in MODE_NONE
  always_comb begin
    if (item_q.scale_mode == MODE_NONE) begin
      w_new = {8'h00, item_q.stroke_width};
    end else if (acc_q[55:47] != '0) begin
      w_new = WIDTH_MAX;
    end else begin
      w_new = {1'b0, acc_q[46:16]};
    end
  end

  // Accumulator status
  assign acc_zero = (acc_q == '0);
  assign acc_neg  = acc_q[ACC_W-1];
  assign acc_pos  = !acc_neg && !acc_zero;
  assign ldiff    = $signed({64'h0, len2_q}) - acc_q;
  assign acc_mag  = acc_neg ? -acc_q : acc_q;

  // Operand selection of the shared multiplier
  always_comb begin
    mul_en  = 1'b1;
    mul_clr = 1'b0;
    mul_neg = 1'b0;
    mul_sh  = SH_0;
    mul_a   = '0;
    mul_b   = '0;
    case (state_q)
      S_SCALE: begin
        mul_clr = 1'b1;
        mul_a   = {10'h000, item_q.stroke_width};
        mul_b   = {2'b00, factor};
      end
      S_W2: begin
        mul_clr = 1'b1;
        mul_a   = we;
        mul_b   = we;
      end
      S_V0: begin
        mul_clr = 1'b1;
        mul_a   = dx;
        mul_b   = dx;
      end
      S_V1: begin
        mul_a = dy;
        mul_b = dy;
      end
      S_V2: begin
        mul_neg = 1'b1;
        mul_a   = we;
        mul_b   = we;
      end
      S_L0: begin
        mul_clr = 1'b1;
        mul_a   = vx;
        mul_b   = vx;
      end
      S_L1: begin
        mul_a = vy;
        mul_b = vy;
      end
      S_D0: begin
        mul_clr = 1'b1;
        mul_a   = vx;
        mul_b   = wx;
      end
      S_D1: begin
        mul_a = vy;
        mul_b = wy;
      end
      S_C0: begin
        mul_clr = 1'b1;
        mul_a   = vx;
        mul_b   = wy;
      end
      S_C1: begin
        mul_neg = 1'b1;
        mul_a   = vy;
        mul_b   = wx;
      end
      S_Q0: begin
        mul_clr = 1'b1;
        mul_a   = {2'b00, crs_q[31:0]};
        mul_b   = {2'b00, crs_q[31:0]};
      end
      S_Q1: begin
        mul_sh = SH_33;
        mul_a  = {2'b00, crs_q[31:0]};
        mul_b  = {2'b00, crs_q[63:32]};
      end
      S_Q2: begin
        mul_sh = SH_64;
        mul_a  = {2'b00, crs_q[63:32]};
        mul_b  = {2'b00, crs_q[63:32]};
      end
      S_Q3: begin
        mul_neg = 1'b1;
        mul_a   = {2'b00, w2_q[31:0]};
        mul_b   = {2'b00, len2_q[31:0]};
      end
      S_Q4: begin
        mul_neg = 1'b1;
        mul_sh  = SH_32;
        mul_a   = {2'b00, w2_q[31:0]};
        mul_b   = $signed(len2_q[65:32]);
      end
      S_Q5: begin
        mul_neg = 1'b1;
        mul_sh  = SH_32;
        mul_a   = {2'b00, w2_q[63:32]};
        mul_b   = {2'b00, len2_q[31:0]};
      end
      S_Q6: begin
        mul_neg = 1'b1;
        mul_sh  = SH_64;
        mul_a   = {2'b00, w2_q[63:32]};
        mul_b   = $signed(len2_q[65:32]);
      end
      S_E0: begin
        mul_clr = 1'b1;
        mul_a   = ex;
        mul_b   = gy;
      end
      S_E1: begin
        mul_neg = 1'b1;
        mul_a   = gx;
        mul_b   = ey;
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Multiply, align and accumulate
  assign prod     = mul_a * mul_b;
  assign prod_ext = {{(ACC_W-68){prod[67]}}, prod};
  always_comb begin
    case (mul_sh)
      SH_32:   term = prod_ext <<< 32;
      SH_33:   term = prod_ext <<< 33;
      SH_64:   term = prod_ext <<< 64;
      default: term = prod_ext;
    endcase
    acc_d = (mul_clr ? '0 : acc_q) + (mul_neg ? -term : term);
  end

  // Skip and hit of the finishing element
  assign result_skip = (kind_q == KIND_POLY) ? (count_q < COUNT_BITS'(3))
                                             : ((count_q < COUNT_BITS'(2)) || zw_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (open_new) begin
            state_d = (in_data_i.prim_kind == KIND_STRIP) ? S_SCALE : S_EEND;
          end else begin
            state_d = (kind_q == KIND_STRIP) ? S_OC : S_ESEL;
          end
        end
      end
      S_SCALE: state_d = S_WSET;
      S_WSET:  state_d = S_W2;
      S_W2:    state_d = S_W2ST;
      S_W2ST:  state_d = S_OC;
      S_OC: begin
        if (oc == 4'h0) begin
          state_d = S_V0;
        end else if (!open_q && ((oc & prev_oc_q) == 4'h0)) begin
          state_d = S_L0;
        end else begin
          state_d = S_FIN;
        end
      end
      S_V0:   state_d = S_V1;
      S_V1:   state_d = S_V2;
      S_V2:   state_d = S_VCHK;
      S_VCHK: state_d = seg_ok_q ? S_L0 : S_FIN;
      S_L0:   state_d = S_L1;
      S_L1:   state_d = S_LST;
      S_LST:  state_d = acc_zero ? S_FIN : S_D0;
      S_D0:   state_d = S_D1;
      S_D1:   state_d = S_DCHK;
      S_DCHK: begin
        if (acc_pos && !ldiff[ACC_W-1] && (ldiff != '0)) begin
          state_d = S_C0;
        end else begin
          state_d = S_FIN;
        end
      end
      S_C0:   state_d = S_C1;
      S_C1:   state_d = S_CST;
      S_CST:  state_d = (acc_mag[ACC_W-1:64] != '0) ? S_FIN : S_Q0;
      S_Q0:   state_d = S_Q1;
      S_Q1:   state_d = S_Q2;
      S_Q2:   state_d = S_Q3;
      S_Q3:   state_d = S_Q4;
      S_Q4:   state_d = S_Q5;
      S_Q5:   state_d = S_Q6;
      S_Q6:   state_d = S_QCHK;
      S_QCHK: state_d = S_FIN;
      S_ESEL: state_d = crossing ? S_E0 : S_EEND;
      S_E0:   state_d = S_E1;
      S_E1:   state_d = S_ECHK;
      S_ECHK: state_d = S_EEND;
      S_EEND: state_d = (item_q.last_vertex && !closing_q) ? S_ESEL : S_FIN;
      S_FIN: begin
        if (!item_q.last_vertex || out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state, configuration and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      qx_q        <= '0;
      qy_q        <= '0;
      sc_norm_q   <= SCALE_RESET;
      sc_vert_q   <= SCALE_RESET;
      sc_horz_q   <= SCALE_RESET;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      start_x_q   <= '0;
      start_y_q   <= '0;
      prev_oc_q   <= '0;
      w_q         <= '0;
      count_q     <= '0;
      parity_q    <= 1'b0;
      hit_q       <= 1'b0;
      kind_q      <= KIND_STRIP;
      zw_q        <= 1'b0;
      open_q      <= 1'b0;
      seg_ok_q    <= 1'b0;
      closing_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Take configuration writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_QUERY_X:    qx_q      <= cfg_data_i;
          REG_QUERY_Y:    qy_q      <= cfg_data_i;
          REG_SCALE_NORM: sc_norm_q <= cfg_data_i;
          REG_SCALE_VERT: sc_vert_q <= cfg_data_i;
          REG_SCALE_HORZ: sc_horz_q <= cfg_data_i;
          default: ;
        endcase
      end

      // Load a finished result, drop a taken one
      if (state_q == S_FIN && item_q.last_vertex && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            open_q    <= open_new;
            closing_q <= 1'b0;
            if (open_new) begin
              kind_q    <= in_data_i.prim_kind;
              zw_q      <= (in_data_i.stroke_width == '0);
              start_x_q <= in_data_i.vert_x;
              start_y_q <= in_data_i.vert_y;
              count_q   <= COUNT_BITS'(1);
              parity_q  <= 1'b0;
              hit_q     <= 1'b0;
              prev_oc_q <= '0;
            end else if (count_q != '1) begin
              count_q <= count_q + COUNT_BITS'(1);
            end
          end
        end
        S_WSET: w_q <= w_new;
        S_OC: begin
          oc_q     <= oc;
          seg_ok_q <= !open_q && ((oc & prev_oc_q) == 4'h0);
        end
        S_VCHK: if (acc_neg || acc_zero) hit_q <= 1'b1;
        S_QCHK: if (acc_neg) hit_q <= 1'b1;
        S_ECHK: begin
          if (ey > 34'sd0 ? acc_neg : acc_pos) parity_q <= !parity_q;
        end
        S_EEND: if (item_q.last_vertex && !closing_q) closing_q <= 1'b1;
        S_FIN: begin
          if (!item_q.last_vertex || out_free) begin
            prev_x_q <= item_q.vert_x;
            prev_y_q <= item_q.vert_y;
            if (kind_q == KIND_STRIP) prev_oc_q <= oc_q;
            if (item_q.last_vertex) count_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_data_i;
    if (mul_en) acc_q <= acc_d;
    if (state_q == S_W2ST) w2_q <= acc_q[63:0];
    if (state_q == S_LST) len2_q <= acc_q[65:0];
    if (state_q == S_CST) crs_q <= acc_mag[63:0];
    if (state_q == S_FIN && item_q.last_vertex && out_free) begin
      out_q.skipped <= result_skip;
      out_q.hit     <= !result_skip && ((kind_q == KIND_POLY) ? parity_q : hit_q);
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_FIN)) else $error("result outside finish");
  a_width_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !w_q[31]) else $error("active width above saturation limit");
  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && item_q.last_vertex && out_free) |=> (count_q == '0))
    else $error("element count not cleared after result");
  a_hit_not_skipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.hit && out_q.skipped)) else $error("skipped element reported hit");
`endif

endmodule
`default_nettype wire
